// ===== rtl/frame_time_statistics_monitor_assert.svh =====
// Assertion macros used by the frame time statistics monitor checker
`ifndef FRAME_TIME_STATISTICS_MONITOR_ASSERT_SVH
`define FRAME_TIME_STATISTICS_MONITOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define FTS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fts_pkg.sv =====
// Package: shared widths, constants and the sequencer state type
`default_nettype none

package fts_pkg;

    localparam int FRAMES_W   = 17;
    localparam int WIN_W      = 16;
    localparam int DRAW_W     = 16;
    localparam int OUT_TIME_W = 24;
    localparam int RATE_W     = 34;
    localparam int ACC_W      = 40;
    localparam int DIV20_W    = 5;

    localparam logic [WIN_W-1:0]   WINDOW_RESET    = 16'd600;
    localparam logic [63:0]        MIN_RESET_UNITS = 64'd2559744;
    localparam logic [RATE_W-1:0]  RATE_NUMERATOR  = 34'd16777216000;
    localparam logic [DIV20_W-1:0] RATE_DIVISOR    = 5'd20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ADD_RATE,
        ST_ADD_TERM,
        ST_START20,
        ST_DIV20,
        ST_OUT
    } fts_state_t;

endpackage

`default_nettype wire

// ===== rtl/frame_time_statistics_monitor.sv =====
// Top level: frame time statistics with running min/max/mean and smoothed rate
`default_nettype none

// Frame time statistics monitor. Each input word carries one frame's duration
// (1/256 ms units) and its draw count; each produces exactly one result word
// with the frame's own values, the running minimum and maximum, the window
// mean and a smoothed frame rate in unsigned 18.16 frames per second. The
// block works on one word at a time: s_ready is high only while the sequencer
// is idle, and a finished result waits in the output register, so the next
// word can be taken while the previous result is still unclaimed. A word is
// not taken before the previous one has loaded its result, and a result
// register that is still held stalls that load. The time a word takes is set
// by the two bit-serial divides in series: the reciprocal
// 256000*65536/frame_time that gives the rate term, then the divide by twenty
// of 19*rate+term, with the multiply-add steps and the hand-offs between them.
// The mean divide runs in parallel with the reciprocal and is hidden under it
// while TIME_BITS is at most RATE_W. The window register (cfg_we/cfg_wdata,
// reset 600) is to be written by the user only while the block is idle; the
// block itself does not enforce this. Once the frame count exceeds it, count,
// sum, minimum and maximum restart, while the reported mean still comes from
// before the restart and the smoothed rate never restarts. There is no
// clearing pass after reset.
module frame_time_statistics_monitor #(
    parameter int TIME_BITS = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [fts_pkg::WIN_W-1:0]     cfg_wdata,
    // input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [TIME_BITS-1:0]          s_frame_time,
    input  wire logic [fts_pkg::DRAW_W-1:0]    s_draw_count,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [fts_pkg::OUT_TIME_W-1:0]     m_last_frame_time,
    output logic [fts_pkg::DRAW_W-1:0]         m_last_draw_count,
    output logic [fts_pkg::OUT_TIME_W-1:0]     m_min_frame_time,
    output logic [fts_pkg::OUT_TIME_W-1:0]     m_max_frame_time,
    output logic [fts_pkg::OUT_TIME_W-1:0]     m_mean_frame_time,
    output logic [fts_pkg::RATE_W-1:0]         m_smoothed_rate,
    output logic                               m_window_restarted
);

    import fts_pkg::*;

    localparam int SUM_W = TIME_BITS + FRAMES_W;
    localparam logic [63:0] TIME_MAX64 = (64'd1 << TIME_BITS) - 64'd1;
    // 9999 ms, saturated to all ones when the time width cannot hold it
    localparam logic [TIME_BITS-1:0] MIN_RESET = (MIN_RESET_UNITS > TIME_MAX64) ?
        TIME_MAX64[TIME_BITS-1:0] : MIN_RESET_UNITS[TIME_BITS-1:0];

    fts_state_t state_reg, state_next;

    // window statistics
    logic [WIN_W-1:0]     window_reg;
    logic [FRAMES_W-1:0]  frames_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [TIME_BITS-1:0] min_reg;
    logic [TIME_BITS-1:0] max_reg;
    logic [RATE_W-1:0]    rate_reg;

    // per-word holding registers
    logic [TIME_BITS-1:0] ft_hold_reg;
    logic [DRAW_W-1:0]    dc_hold_reg;
    logic [TIME_BITS-1:0] min_hold_reg;
    logic [TIME_BITS-1:0] max_hold_reg;
    logic                 rst_hold_reg;
    logic [ACC_W-1:0]     acc_reg;

    // result register
    logic                  m_valid_reg;
    logic [OUT_TIME_W-1:0] m_last_ft_reg;
    logic [DRAW_W-1:0]     m_last_dc_reg;
    logic [OUT_TIME_W-1:0] m_min_reg;
    logic [OUT_TIME_W-1:0] m_max_reg;
    logic [OUT_TIME_W-1:0] m_mean_reg;
    logic [RATE_W-1:0]     m_rate_reg;
    logic                  m_rst_reg;

    // sequencer outputs
    logic ready_int;
    logic div_start;
    logic div20_start;
    logic out_load;
    logic accept;

    // accept-cycle arithmetic
    logic [FRAMES_W-1:0]  count_inc;
    logic [SUM_W-1:0]     sum_upd;
    logic [TIME_BITS-1:0] min_upd;
    logic [TIME_BITS-1:0] max_upd;
    logic                 restart;

    // divider hookups
    logic                 mean_busy;
    logic [TIME_BITS-1:0] mean_q;
    logic                 recip_busy;
    logic [RATE_W-1:0]    recip_q;
    logic                 div20_busy;
    logic [ACC_W-1:0]     div20_q;
    logic [RATE_W-1:0]    term;

    assign accept = s_valid && ready_int;

    // Update the window on the accepting edge; the mean divide sees the
    // pre-restart count and sum, the held min/max see the post-restart ones.
    assign count_inc = frames_reg + FRAMES_W'(1);
    assign sum_upd   = sum_reg + SUM_W'(s_frame_time);
    assign min_upd   = (s_frame_time < min_reg) ? s_frame_time : min_reg;
    assign max_upd   = (s_frame_time > max_reg) ? s_frame_time : max_reg;
    assign restart   = (count_inc > FRAMES_W'(window_reg));

    // zero frame time contributes no rate term
    assign term = (ft_hold_reg == '0) ? '0 : recip_q;

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!mean_busy && !recip_busy) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:      state_next = ST_ADD_RATE;
            ST_ADD_RATE: state_next = ST_ADD_TERM;
            ST_ADD_TERM: state_next = ST_START20;
            ST_START20:  state_next = ST_DIV20;
            ST_DIV20: begin
                if (!div20_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        ready_int   = 1'b0;
        div_start   = 1'b0;
        div20_start = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                ready_int = 1'b1;
                div_start = s_valid;
            end
            ST_START20: begin
                div20_start = 1'b1;
            end
            ST_OUT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                ready_int = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- configuration and window state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            frames_reg <= '0;
            sum_reg    <= '0;
            min_reg    <= MIN_RESET;
            max_reg    <= '0;
            rate_reg   <= '0;
        end else begin
            if (cfg_we) begin
                window_reg <= cfg_wdata;
            end
            if (accept) begin
                if (restart) begin
                    frames_reg <= '0;
                    sum_reg    <= '0;
                    min_reg    <= MIN_RESET;
                    max_reg    <= '0;
                end else begin
                    frames_reg <= count_inc;
                    sum_reg    <= sum_upd;
                    min_reg    <= min_upd;
                    max_reg    <= max_upd;
                end
            end
            if (out_load) begin
                rate_reg <= div20_q[RATE_W-1:0];
            end
        end
    end

    // ---------------- per-word datapath ----------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            ft_hold_reg  <= s_frame_time;
            dc_hold_reg  <= s_draw_count;
            min_hold_reg <= restart ? MIN_RESET : min_upd;
            max_hold_reg <= restart ? '0 : max_upd;
            rst_hold_reg <= restart;
        end
        // build 19*rate + term one add per cycle
        case (state_reg)
            ST_MUL:      acc_reg <= ACC_W'({rate_reg, 4'b0000}) + ACC_W'({rate_reg, 1'b0});
            ST_ADD_RATE: acc_reg <= acc_reg + ACC_W'(rate_reg);
            ST_ADD_TERM: acc_reg <= acc_reg + ACC_W'(term);
            default:     acc_reg <= acc_reg;
        endcase
    end

    // mean = sum / count; the sum's upper part is already below the count
    fts_div #(
        .DVS_W (FRAMES_W),
        .Q_W   (TIME_BITS)
    ) u_mean_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (sum_upd[SUM_W-1:TIME_BITS]),
        .dvd_lo   (sum_upd[TIME_BITS-1:0]),
        .divisor  (count_inc),
        .busy     (mean_busy),
        .quotient (mean_q)
    );

    // rate term = 256000*65536 / frame_time
    fts_div #(
        .DVS_W (TIME_BITS),
        .Q_W   (RATE_W)
    ) u_recip_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init ('0),
        .dvd_lo   (RATE_NUMERATOR),
        .divisor  (s_frame_time),
        .busy     (recip_busy),
        .quotient (recip_q)
    );

    // smoothed rate = (19*rate + term) / 20
    fts_div #(
        .DVS_W (DIV20_W),
        .Q_W   (ACC_W)
    ) u_div20 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div20_start),
        .rem_init ('0),
        .dvd_lo   (acc_reg),
        .divisor  (RATE_DIVISOR),
        .busy     (div20_busy),
        .quotient (div20_q)
    );

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_last_ft_reg <= OUT_TIME_W'(ft_hold_reg);
            m_last_dc_reg <= dc_hold_reg;
            m_min_reg     <= OUT_TIME_W'(min_hold_reg);
            m_max_reg     <= OUT_TIME_W'(max_hold_reg);
            m_mean_reg    <= OUT_TIME_W'(mean_q);
            m_rate_reg    <= div20_q[RATE_W-1:0];
            m_rst_reg     <= rst_hold_reg;
        end
    end

    assign s_ready            = ready_int;
    assign m_valid            = m_valid_reg;
    assign m_last_frame_time  = m_last_ft_reg;
    assign m_last_draw_count  = m_last_dc_reg;
    assign m_min_frame_time   = m_min_reg;
    assign m_max_frame_time   = m_max_reg;
    assign m_mean_frame_time  = m_mean_reg;
    assign m_smoothed_rate    = m_rate_reg;
    assign m_window_restarted = m_rst_reg;

endmodule

`default_nettype wire

// ===== rtl/fts_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle
`default_nettype none

module fts_div #(
    parameter int DVS_W = 17,
    parameter int Q_W   = 24
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVS_W-1:0] rem_init,
    input  wire logic [Q_W-1:0]   dvd_lo,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  busy,
    output logic [Q_W-1:0]        quotient
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DVS_W-1:0] rem_reg;
    logic [Q_W-1:0]   shift_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W+1:0] diff;
    logic             borrow;

    // rem_init must be below the divisor so the quotient fits Q_W bits
    assign trial  = {rem_reg, shift_reg[Q_W-1]};
    assign diff   = {1'b0, trial} - {2'b00, dvs_reg};
    assign borrow = diff[DVS_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(Q_W);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            busy_reg <= (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= rem_init;
            shift_reg <= dvd_lo;
            dvs_reg   <= divisor;
        end else if (busy_reg) begin
            rem_reg   <= borrow ? trial[DVS_W-1:0] : diff[DVS_W-1:0];
            shift_reg <= {shift_reg[Q_W-2:0], ~borrow};
        end
    end

    assign busy     = busy_reg;
    assign quotient = shift_reg;

endmodule

`default_nettype wire

// ===== rtl/fts_chk.sv =====
// Port-level checker for the frame time statistics monitor, with its bind
`default_nettype none

`include "frame_time_statistics_monitor_assert.svh"

module fts_chk #(
    parameter int TIME_BITS = 24
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          cfg_we,
    input wire logic [fts_pkg::WIN_W-1:0]     cfg_wdata,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic [TIME_BITS-1:0]          s_frame_time,
    input wire logic [fts_pkg::DRAW_W-1:0]    s_draw_count,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [fts_pkg::OUT_TIME_W-1:0] m_last_frame_time,
    input wire logic [fts_pkg::DRAW_W-1:0]    m_last_draw_count,
    input wire logic [fts_pkg::OUT_TIME_W-1:0] m_min_frame_time,
    input wire logic [fts_pkg::OUT_TIME_W-1:0] m_max_frame_time,
    input wire logic [fts_pkg::OUT_TIME_W-1:0] m_mean_frame_time,
    input wire logic [fts_pkg::RATE_W-1:0]    m_smoothed_rate,
    input wire logic                          m_window_restarted
);

    import fts_pkg::*;

    // ordering checks only hold when times are reported without truncation
    localparam bit EXACT = (TIME_BITS <= OUT_TIME_W);

    logic in_word;
    logic out_stall;
    logic ordered_ok;

    assign in_word    = s_valid && s_ready;
    assign out_stall  = m_valid && !m_ready;
    assign ordered_ok = (m_min_frame_time <= m_last_frame_time) &&
                        (m_last_frame_time <= m_max_frame_time) &&
                        (m_min_frame_time <= m_mean_frame_time) &&
                        (m_mean_frame_time <= m_max_frame_time);

    // a stalled result stays valid and holds its smoothed rate and mean
    `FTS_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall,
        m_valid && $stable(m_smoothed_rate) && $stable(m_mean_frame_time),
        "stalled result changed")

    // one word at a time: input closes right after an accept
    `FTS_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, in_word, !s_ready,
        "input still open after accepting a word")

    // a restart reports an emptied maximum
    `FTS_ASSERT_NOW(a_restart_max, aclk, aresetn, m_valid && m_window_restarted,
        m_max_frame_time == '0, "restart did not clear the maximum")

    // without restart the frame and the mean lie between minimum and maximum
    `FTS_ASSERT_NOW(a_ordered, aclk, aresetn, EXACT && m_valid && !m_window_restarted,
        ordered_ok, "min/last/mean/max out of order")

endmodule

bind frame_time_statistics_monitor fts_chk #(.TIME_BITS(TIME_BITS)) u_fts_chk (.*);

`default_nettype wire
